FILE: hdl/afg_pkg.sv
// Package for the audio frame FIFO with gain: sizes, opcodes, state codes
// and the structs passed between the ring, the lanes and the top level.
// No dependencies.
`timescale 1ns / 1ps

package afg_pkg;

  localparam int RING_FRAMES = 4096;
  localparam int IDX_W       = $clog2(RING_FRAMES);
  localparam int FILL_W      = $clog2(RING_FRAMES + 1);
  localparam int SAMPLE_W    = 16;
  localparam int VOL_W       = 16;
  localparam int COUNT_W     = 32;
  localparam int PROD_W      = SAMPLE_W + VOL_W + 1;
  localparam int FRAC_W      = 15;

  localparam logic [VOL_W-1:0] UNITY_GATE   = 16'd32735;
  localparam logic [VOL_W-1:0] VOLUME_RESET = 16'd32768;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_PULL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic {
    REG_VOLUME = 1'b0,
    REG_PAUSED = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               accepted;
    logic               frame_valid;
    logic [FILL_W-1:0]  buffered_frames;
    logic [COUNT_W-1:0] emitted_count;
  } ring_status_t;

  typedef struct packed {
    logic load;
    logic active;
    logic pass;
  } lane_ctrl_t;

endpackage

FILE: hdl/afg_if.sv
// Handshake channels of the audio frame FIFO: the item channel carrying
// an opcode and a frame, and the result channel. Depends on afg_pkg.
`timescale 1ns / 1ps

interface afg_item_if import afg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, output opcode, output left_sample, output right_sample,
                  input ready);
  modport sink (input valid, input opcode, input left_sample, input right_sample,
                output ready);
endinterface

interface afg_result_if import afg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic                       frame_valid;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic [FILL_W-1:0]          buffered_frames;
  logic [COUNT_W-1:0]         emitted_count;

  modport source (output valid, output accepted, output frame_valid, output left_out,
                  output right_out, output buffered_frames, output emitted_count,
                  input ready);
  modport sink (input valid, input accepted, input frame_valid, input left_out,
                input right_out, input buffered_frames, input emitted_count,
                output ready);
endinterface

FILE: hdl/afg_ring.sv
// Frame ring: the frame memory, read and write pointers, fill count and
// saturating written-frame counter. Depends on afg_pkg.
`timescale 1ns / 1ps

module afg_ring import afg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  opcode_t             opcode,
  input  logic [2*SAMPLE_W-1:0] frame,
  input  logic                paused,
  output logic [2*SAMPLE_W-1:0] rd_data,
  output ring_status_t        status
);

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(RING_FRAMES - 1);
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(RING_FRAMES);

  logic [2*SAMPLE_W-1:0] store [RING_FRAMES];

  logic [IDX_W-1:0]   read_index;
  logic [IDX_W-1:0]   write_index;
  logic [FILL_W-1:0]  fill_count;
  logic [COUNT_W-1:0] written_total;
  logic               accepted;
  logic               frame_valid;

  logic push_ok;
  logic pull_ok;
  logic do_clear;
  logic [COUNT_W-1:0] fill_wide;

  assign push_ok  = start && (opcode == OP_PUSH) && (fill_count < FULL);
  assign pull_ok  = start && (opcode == OP_PULL) && !paused && (fill_count != '0);
  assign do_clear = start && (opcode == OP_CLEAR);

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[write_index] <= frame;
    end
    if (start) begin
      rd_data <= store[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index    <= '0;
      write_index   <= '0;
      fill_count    <= '0;
      written_total <= '0;
      accepted      <= 1'b0;
      frame_valid   <= 1'b0;
    end else begin
      if (start) begin
        accepted    <= push_ok;
        frame_valid <= pull_ok;
      end
      if (do_clear) begin
        read_index    <= '0;
        write_index   <= '0;
        fill_count    <= '0;
        written_total <= '0;
      end else if (push_ok) begin
        write_index <= (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
        fill_count  <= fill_count + 1'b1;
        if (written_total != '1) begin
          written_total <= written_total + 1'b1;
        end
      end else if (pull_ok) begin
        read_index <= (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
        fill_count <= fill_count - 1'b1;
      end
    end
  end

  assign fill_wide = COUNT_W'(fill_count);

  always_comb begin
    status.accepted        = accepted;
    status.frame_valid     = frame_valid;
    status.buffered_frames = fill_count;
    status.emitted_count   = (written_total >= fill_wide) ? written_total - fill_wide : '0;
  end

endmodule

FILE: hdl/afg_lane.sv
// Gain lane: zero if inactive, raw sample if pass, else sample times the
// Q1.15 volume, truncated toward zero, saturated. Depends on afg_pkg.
`timescale 1ns / 1ps

module afg_lane import afg_pkg::*; (
  input  logic                       clk,
  input  lane_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [VOL_W-1:0]           volume,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam logic signed [PROD_W-1:0] ROUND_FIX = PROD_W'((1 << FRAC_W) - 1);
  localparam logic signed [PROD_W-1:0] SAT_HI    = PROD_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO    = -PROD_W'(1 << (SAMPLE_W - 1));

  logic signed [PROD_W-1:0]   product;
  logic signed [SAMPLE_W-1:0] raw;
  logic                       active;
  logic                       pass;

  logic signed [PROD_W-1:0] adjusted;
  logic signed [PROD_W-1:0] quotient;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      product <= PROD_W'(sample) * $signed({1'b0, volume});
      raw     <= sample;
      active  <= ctrl.active;
      pass    <= ctrl.pass;
    end
  end

  always_comb begin
    adjusted = product + (product[PROD_W-1] ? ROUND_FIX : '0);
    quotient = adjusted >>> FRAC_W;
    if (!active) begin
      result = '0;
    end else if (pass) begin
      result = raw;
    end else if (quotient > SAT_HI) begin
      result = SAT_HI[SAMPLE_W-1:0];
    end else if (quotient < SAT_LO) begin
      result = SAT_LO[SAMPLE_W-1:0];
    end else begin
      result = quotient[SAMPLE_W-1:0];
    end
  end

endmodule

FILE: hdl/audio_frame_fifo_with_gain_top.sv
// Top level of the audio frame FIFO with gain: register port, sequencer,
// two gain lanes and the merging output register.
// Depends on afg_pkg, afg_if, afg_ring and afg_lane.
//
// Usage: each beat on the item channel carries an opcode (push, pull,
// clear, or a no-op) and a stereo frame. Every item gives exactly one beat
// on the result channel with the accept and valid flags, the scaled left
// and right samples, the buffered frame count and the emitted frame count.
// Volume and pause must be written through the APB port only while the block
// is idle; the block itself does not enforce this. For each item, the frame
// memory read and the ring update happen at the accepting edge, the lane
// multiply is registered in ST_MUL, and saturation and merging of both lanes
// feed the output register from ST_OUT.
// The sequencer holds one item at a time, so a new item is accepted only
// once the previous one has left the sequencer. The output register lets the
// next item be accepted while the previous result waits.
// When the receiver stalls, the finished item holds in the sequencer until
// the output register frees up, and the item channel stays not ready.
// Reset empties the ring, zeroes the counters, sets the volume to unity and
// clears pause; the frame memory itself is not cleared. The item channel is
// not ready while reset is held.
`timescale 1ns / 1ps

module audio_frame_fifo_with_gain_top import afg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  afg_item_if.sink           item,
  afg_result_if.source       result
);

  logic [VOL_W-1:0] volume;
  logic             paused;
  logic             cfg_write;
  reg_index_t       cfg_index;

  state_t state;
  state_t state_next;

  logic         start;
  logic         out_load;
  lane_ctrl_t   lane_ctrl;
  ring_status_t status;
  logic [2*SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] left_lane;
  logic signed [SAMPLE_W-1:0] right_lane;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= VOLUME_RESET;
      paused <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VOLUME: volume <= pwdata[VOL_W-1:0];
        REG_PAUSED: paused <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_VOLUME: prdata = DATA_W'(volume);
      REG_PAUSED: prdata = DATA_W'(paused);
      default:    prdata = '0;
    endcase
  end

  assign item.ready = (state == ST_IDLE) && !rst;
  assign start      = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    out_load         = 1'b0;
    lane_ctrl.load   = 1'b0;
    lane_ctrl.active = status.frame_valid;
    lane_ctrl.pass   = (volume >= UNITY_GATE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        lane_ctrl.load = 1'b1;
        state_next     = ST_OUT;
      end
      ST_OUT: begin
        if (!result.valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  afg_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .opcode  (opcode_t'(item.opcode)),
    .frame   ({item.right_sample, item.left_sample}),
    .paused  (paused),
    .rd_data (rd_data),
    .status  (status)
  );

  afg_lane u_lane_left (
    .clk    (clk),
    .ctrl   (lane_ctrl),
    .sample (rd_data[SAMPLE_W-1:0]),
    .volume (volume),
    .result (left_lane)
  );

  afg_lane u_lane_right (
    .clk    (clk),
    .ctrl   (lane_ctrl),
    .sample (rd_data[2*SAMPLE_W-1:SAMPLE_W]),
    .volume (volume),
    .result (right_lane)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.accepted        <= status.accepted;
      result.frame_valid     <= status.frame_valid;
      result.left_out        <= left_lane;
      result.right_out       <= right_lane;
      result.buffered_frames <= status.buffered_frames;
      result.emitted_count   <= status.emitted_count;
    end
  end

endmodule
